@@ rtl/hfp_pkg.sv @@
package hfp_pkg;

  localparam logic [23:0] HdrBytes  = 24'd9;
  localparam logic [3:0]  PrioBytes = 4'd5;
  localparam logic [3:0]  PingBytes = 4'd8;
  localparam logic [3:0]  WordBytes = 4'd4;

  localparam logic [7:0] FtData         = 8'd0;
  localparam logic [7:0] FtHeaders      = 8'd1;
  localparam logic [7:0] FtPriority     = 8'd2;
  localparam logic [7:0] FtRstStream    = 8'd3;
  localparam logic [7:0] FtSettings     = 8'd4;
  localparam logic [7:0] FtPushPromise  = 8'd5;
  localparam logic [7:0] FtPing         = 8'd6;
  localparam logic [7:0] FtGoaway       = 8'd7;
  localparam logic [7:0] FtWindowUpdate = 8'd8;
  localparam logic [7:0] FtContinuation = 8'd9;

  localparam int unsigned FlagAck      = 0;
  localparam int unsigned FlagPadded   = 3;
  localparam int unsigned FlagPriority = 5;

  localparam logic KindContent    = 1'b0;
  localparam logic KindDescriptor = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SIZE    = 2'd1,
    ST_PROTO   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    status_e status;
    logic    lvl;
  } chk_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  fill;
    logic [31:0] word_b;
    logic [31:0] word_a;
    logic [23:0] content_length;
    logic [7:0]  pad_length;
    logic        stream_level;
    logic [1:0]  status;
    logic [31:0] stream_number;
    logic [23:0] frame_length;
    logic [7:0]  frame_flags;
    logic [7:0]  frame_type;
    logic [7:0]  content_byte;
  } out_data_t;

  typedef struct packed {
    logic      valid;
    logic      kind;
    out_data_t data;
  } res_t;

  function automatic logic pad_flag(logic [7:0] typ, logic [7:0] flags);
    return ((typ == FtData) || (typ == FtHeaders) || (typ == FtPushPromise)) &&
           flags[FlagPadded];
  endfunction

  function automatic logic [3:0] fixed_bytes(logic [7:0] typ, logic [7:0] flags);
    logic [3:0] r;
    case (typ) inside
      FtHeaders:                               r = flags[FlagPriority] ? PrioBytes : 4'd0;
      FtPriority:                              r = PrioBytes;
      FtRstStream, FtPushPromise, FtWindowUpdate: r = WordBytes;
      FtPing, FtGoaway:                        r = PingBytes;
      default:                                 r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mod3_add(logic [1:0] m, logic [7:0] b);
    logic [3:0] s;
    s = {2'b0, b[1:0]} + {2'b0, b[3:2]} + {2'b0, b[5:4]} + {2'b0, b[7:6]} + {2'b0, m};
    if (s >= 4'd12) begin
      s = s - 4'd12;
    end else if (s >= 4'd9) begin
      s = s - 4'd9;
    end else if (s >= 4'd6) begin
      s = s - 4'd6;
    end else if (s >= 4'd3) begin
      s = s - 4'd3;
    end
    return s[1:0];
  endfunction

  function automatic chk_t run_checks(logic [23:0] len, logic [7:0] typ, logic [7:0] flags,
                                      logic [31:0] stream, logic [7:0] pad, logic [1:0] mod3);
    chk_t       r;
    logic       pf;
    logic [3:0] fb;
    logic [3:0] p;
    logic       size_bad;
    logic       lvl;
    r.status = ST_OK;
    r.lvl    = 1'b0;
    pf       = pad_flag(typ, flags);
    fb       = fixed_bytes(typ, flags);
    p        = fb + {3'b0, pf};
    size_bad = 1'b0;
    lvl      = 1'b0;
    if (typ > FtContinuation) begin
      r.status = ST_UNKNOWN;
    end else if (pf && ({16'd0, pad} >= len)) begin
      r.status = ST_PROTO;
    end else begin
      case (typ) inside
        FtRstStream, FtPing, FtWindowUpdate: size_bad = (len != {20'd0, fb});
        FtSettings: size_bad = flags[FlagAck] ? (len != 24'd0) : (len[0] || (mod3 != 2'd0));
        default: begin
          size_bad = (len < {20'd0, p});
          lvl      = (typ == FtPriority);
        end
      endcase
      if (size_bad) begin
        r.status = ST_SIZE;
        r.lvl    = lvl;
      end else if (pf && (({17'd0, pad} + {21'd0, p}) > {1'b0, len})) begin
        r.status = ST_PROTO;
      end else begin
        case (typ) inside
          FtSettings, FtPing, FtGoaway: if (stream != 32'd0) r.status = ST_PROTO;
          FtWindowUpdate, FtContinuation: r.status = ST_OK;
          default: if (stream == 32'd0) r.status = ST_PROTO;
        endcase
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/hfp_in_stage.sv @@
module hfp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [7:0]        s_tdata_i,
  input  logic              advance_i,
  output hfp_pkg::in_beat_t beat_o
);

  logic       valid_q;
  logic [7:0] data_q;

  assign s_tready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_tready_o) begin
      valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      data_q <= s_tdata_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

endmodule

@@ rtl/hfp_core.sv @@
module hfp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic [7:0]    byte_i,
  output hfp_pkg::res_t res_o
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PREFIX = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [23:0] cnt_q, cnt_d;
  logic [23:0] len_q, len_d;
  logic [1:0]  mod3_q, mod3_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] stream_q, stream_d;
  logic [7:0]  pad_q, pad_d;
  logic [31:0] wa_q, wa_d;
  logic [31:0] wb_q, wb_d;
  logic        halted_q, halted_d;

  logic             pf;
  logic [3:0]       fb;
  logic [3:0]       plen;
  logic [3:0]       k;
  logic [31:0]      stream_shift;
  hfp_pkg::chk_t    chk_hdr;
  hfp_pkg::chk_t    chk_pad;
  logic             desc;
  hfp_pkg::status_e st;
  logic             lvl;
  logic             content;
  logic [7:0]       pad_used;
  logic             err;

  assign pf           = hfp_pkg::pad_flag(type_q, flags_q);
  assign fb           = hfp_pkg::fixed_bytes(type_q, flags_q);
  assign plen         = fb + {3'b0, pf};
  assign k            = cnt_q[3:0] - {3'b0, pf};
  assign stream_shift = {stream_q[23:0], byte_i};
  assign chk_hdr      = hfp_pkg::run_checks(len_q, type_q, flags_q, stream_shift, 8'd0, mod3_q);
  assign chk_pad      = hfp_pkg::run_checks(len_q, type_q, flags_q, stream_q, byte_i, mod3_q);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    mod3_d   = mod3_q;
    type_d   = type_q;
    flags_d  = flags_q;
    stream_d = stream_q;
    pad_d    = pad_q;
    wa_d     = wa_q;
    wb_d     = wb_q;
    halted_d = halted_q;
    desc     = 1'b0;
    st       = hfp_pkg::ST_OK;
    lvl      = 1'b0;
    content  = 1'b0;
    if (adv_i && !halted_q) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (cnt_q[3:0] < 4'd3) begin
            len_d  = {len_q[15:0], byte_i};
            mod3_d = hfp_pkg::mod3_add((cnt_q[3:0] == 4'd0) ? 2'd0 : mod3_q, byte_i);
          end else if (cnt_q[3:0] == 4'd3) begin
            type_d = byte_i;
          end else if (cnt_q[3:0] == 4'd4) begin
            flags_d = byte_i;
          end else begin
            stream_d = stream_shift;
          end
          cnt_d = cnt_q + 24'd1;
          if (cnt_d == hfp_pkg::HdrBytes) begin
            cnt_d = 24'd0;
            pad_d = 8'd0;
            wa_d  = 32'd0;
            wb_d  = 32'd0;
            if (pf) begin
              if (len_q == 24'd0) begin
                desc = 1'b1;
                st   = hfp_pkg::ST_SIZE;
              end else begin
                phase_d = PH_PREFIX;
              end
            end else if ((chk_hdr.status == hfp_pkg::ST_SIZE) ||
                         (chk_hdr.status == hfp_pkg::ST_PROTO) || (plen == 4'd0)) begin
              desc = 1'b1;
              st   = chk_hdr.status;
              lvl  = chk_hdr.lvl;
            end else begin
              phase_d = PH_PREFIX;
            end
          end
        end
        PH_PREFIX: begin
          if (pf && (cnt_q == 24'd0)) begin
            pad_d = byte_i;
            cnt_d = 24'd1;
            if ((chk_pad.status == hfp_pkg::ST_SIZE) || (chk_pad.status == hfp_pkg::ST_PROTO) ||
                (plen <= 4'd1)) begin
              desc = 1'b1;
              st   = chk_pad.status;
              lvl  = chk_pad.lvl;
            end
          end else begin
            if (k < hfp_pkg::WordBytes) begin
              wa_d = {wa_q[23:0], byte_i};
            end else if (fb == hfp_pkg::PrioBytes) begin
              wb_d = {24'd0, byte_i};
            end else begin
              wb_d = {wb_q[23:0], byte_i};
            end
            cnt_d = cnt_q + 24'd1;
            if (cnt_d >= {20'd0, plen}) begin
              desc = 1'b1;
            end
          end
        end
        PH_BODY: begin
          if ((type_q <= hfp_pkg::FtContinuation) &&
              (({1'b0, cnt_q} + {17'd0, pf ? pad_q : 8'd0}) < {1'b0, len_q})) begin
            content = 1'b1;
          end
          cnt_d = cnt_q + 24'd1;
          if (({1'b0, cnt_q} + 25'd1) >= {1'b0, len_q}) begin
            phase_d = PH_HEADER;
            cnt_d   = 24'd0;
          end
        end
        default: begin
          phase_d = PH_HEADER;
          cnt_d   = 24'd0;
        end
      endcase
      if (desc) begin
        if ((st == hfp_pkg::ST_SIZE) || (st == hfp_pkg::ST_PROTO)) begin
          halted_d = 1'b1;
        end else if (cnt_d >= len_q) begin
          phase_d = PH_HEADER;
          cnt_d   = 24'd0;
        end else begin
          phase_d = PH_BODY;
        end
      end
    end
  end

  assign err      = (st == hfp_pkg::ST_SIZE) || (st == hfp_pkg::ST_PROTO);
  assign pad_used = pf ? pad_d : 8'd0;

  always_comb begin
    res_o       = '0;
    res_o.valid = desc || content;
    if (desc) begin
      res_o.kind                = hfp_pkg::KindDescriptor;
      res_o.data.frame_type     = type_d;
      res_o.data.frame_flags    = flags_d;
      res_o.data.frame_length   = len_d;
      res_o.data.stream_number  = stream_d;
      res_o.data.status         = st;
      res_o.data.stream_level   = lvl;
      res_o.data.pad_length     = pad_used;
      if (st == hfp_pkg::ST_UNKNOWN) begin
        res_o.data.content_length = len_q;
      end else if (st == hfp_pkg::ST_OK) begin
        res_o.data.content_length = len_q - {20'd0, plen} - {16'd0, pad_used};
      end
      res_o.data.word_a = err ? 32'd0 : wa_d;
      res_o.data.word_b = err ? 32'd0 : wb_d;
    end else begin
      res_o.kind              = hfp_pkg::KindContent;
      res_o.data.content_byte = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      cnt_q    <= 24'd0;
      len_q    <= 24'd0;
      mod3_q   <= 2'd0;
      type_q   <= 8'd0;
      flags_q  <= 8'd0;
      stream_q <= 32'd0;
      pad_q    <= 8'd0;
      wa_q     <= 32'd0;
      wb_q     <= 32'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      mod3_q   <= mod3_d;
      type_q   <= type_d;
      flags_q  <= flags_d;
      stream_q <= stream_d;
      pad_q    <= pad_d;
      wa_q     <= wa_d;
      wb_q     <= wb_d;
      halted_q <= halted_d;
    end
  end

endmodule

@@ rtl/hfp_out_stage.sv @@
module hfp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hfp_pkg::res_t      res_i,
  output logic               ready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic               m_tuser_o,
  output hfp_pkg::out_data_t m_tdata_o
);

  logic               valid_q;
  logic               kind_q;
  hfp_pkg::out_data_t data_q;

  assign ready_o = !valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_i.valid) begin
      kind_q <= res_i.kind;
      data_q <= res_i.data;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tuser_o  = kind_q;
  assign m_tdata_o  = data_q;

endmodule

@@ rtl/http2_frame_parser.sv @@
// HTTP/2 frame parser.
// The slave channel takes the frame stream one byte per beat on s_axis_tdata_i.
// The parser gathers each 9-byte frame header, reads the pad byte and the fixed
// fields of the known frame types, checks them and then sends one frame
// descriptor beat (m_axis_tuser_o high). Content bytes follow as beats with
// m_axis_tuser_o low; padding is dropped. Unknown types give a descriptor with
// the unknown status and their payload is skipped. After a size or protocol
// error descriptor every further byte is dropped until reset.
// An accepted input beat passes through one input register, then the decode
// logic into the output register, before its result shows on the master
// channel. One byte is taken every cycle while the master side accepts.
// When the receiver stalls, the output register holds its beat and the input
// register holds one more byte, after which s_axis_tready_o falls.
// Reset clears the parser to the start of a frame header and empties both
// registers; no clearing pass is needed.
module http2_frame_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] stream_byte
  input  logic [7:0]   s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] content_byte, [15:8] frame_type, [23:16] frame_flags,
  // [47:24] frame_length, [79:48] stream_number, [81:80] status,
  // [82] stream_level, [90:83] pad_length, [114:91] content_length,
  // [146:115] word_a, [178:147] word_b, [183:179] zero
  output logic [183:0] m_axis_tdata_o,
  // [0] result_kind
  output logic         m_axis_tuser_o
);

  hfp_pkg::in_beat_t  beat;
  hfp_pkg::res_t      res;
  hfp_pkg::out_data_t out_data;
  logic               out_ready;
  logic               advance;

  assign advance = beat.valid && out_ready;

  hfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .advance_i  (advance),
    .beat_o     (beat)
  );

  hfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (advance),
    .byte_i (beat.data),
    .res_o  (res)
  );

  hfp_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .ready_o    (out_ready),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tdata_o  (out_data)
  );

  assign m_axis_tdata_o = out_data;

endmodule

@@ rtl/hfp_checker.sv @@
module hfp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [183:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  logic err_beat;

  assign err_beat = m_axis_tvalid_o && m_axis_tready_i &&
                    (m_axis_tuser_o == hfp_pkg::KindDescriptor) &&
                    ((m_axis_tdata_o[81:80] == 2'(hfp_pkg::ST_SIZE)) ||
                     (m_axis_tdata_o[81:80] == 2'(hfp_pkg::ST_PROTO)));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled output beat changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_beat |=> !m_axis_tvalid_o)
    else $error("Output beat after an error descriptor.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == hfp_pkg::KindContent) |->
      (m_axis_tdata_o[183:8] == 176'd0))
    else $error("Content beat carries descriptor fields.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[82] |->
      (m_axis_tuser_o == hfp_pkg::KindDescriptor) &&
      (m_axis_tdata_o[81:80] == 2'(hfp_pkg::ST_SIZE)))
    else $error("Stream level flag without a frame size error.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("Input stalled while the output register was empty.");

endmodule

bind http2_frame_parser hfp_checker u_hfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam int unsigned SettingSize = 6;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseBytes  = 210;
  localparam logic [7:0]  AckBit      = 8'(1 << hfp_pkg::FlagAck);
  localparam logic [7:0]  PadBit      = 8'(1 << hfp_pkg::FlagPadded);
  localparam logic [7:0]  PrioBit     = 8'(1 << hfp_pkg::FlagPriority);
  localparam logic [7:0]  FtLastUnknown = 8'hFF;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PREFIX,
    PH_BODY
  } parse_phase_e;

  typedef struct packed {
    logic               kind;
    hfp_pkg::out_data_t data;
  } beat_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [183:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  http2_frame_parser u_top (.*);

  parse_phase_e ph = PH_HEADER;
  logic [23:0]  byte_cnt = '0;
  logic [23:0]  hdr_len = '0;
  logic [7:0]   hdr_type = '0;
  logic [7:0]   hdr_flags = '0;
  logic [31:0]  hdr_stream = '0;
  logic [7:0]   pad_val = '0;
  logic [31:0]  word_a = '0;
  logic [31:0]  word_b = '0;
  logic         halted = 1'b0;

  beat_t        expected_q[$];
  logic [7:0]   byte_q[$];
  logic [7:0]   body_q[$];

  int unsigned  send_idle = 0;
  int unsigned  recv_idle = 0;
  int unsigned  hold_cnt = HoldCycles;
  int unsigned  quiet_cnt = 0;
  int unsigned  bytes_queued = 0;
  int unsigned  n_err = 0;
  int unsigned  n_in = 0;
  int unsigned  n_desc = 0;
  int unsigned  n_content = 0;
  logic         in_taken = 1'b0;

  task automatic put_byte(logic [7:0] b);
    byte_q.insert(byte_q.size(), b);
  endtask

  task automatic put_body(logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endtask

  task automatic put_expected(beat_t e);
    expected_q.insert(expected_q.size(), e);
  endtask

  function automatic logic padded_of(logic [7:0] typ, logic [7:0] flags);
    return (typ == hfp_pkg::FtData || typ == hfp_pkg::FtHeaders ||
            typ == hfp_pkg::FtPushPromise) && flags[hfp_pkg::FlagPadded];
  endfunction

  function automatic int unsigned fixed_of(logic [7:0] typ, logic [7:0] flags);
    case (typ)
      hfp_pkg::FtHeaders:
        return flags[hfp_pkg::FlagPriority] ? hfp_pkg::PrioBytes : 0;
      hfp_pkg::FtPriority:
        return hfp_pkg::PrioBytes;
      hfp_pkg::FtRstStream, hfp_pkg::FtPushPromise, hfp_pkg::FtWindowUpdate:
        return hfp_pkg::WordBytes;
      hfp_pkg::FtPing, hfp_pkg::FtGoaway:
        return hfp_pkg::PingBytes;
      default:
        return 0;
    endcase
  endfunction

  function automatic int unsigned prefix_len();
    return int'(padded_of(hdr_type, hdr_flags)) + fixed_of(hdr_type, hdr_flags);
  endfunction

  function automatic hfp_pkg::status_e frame_check(output logic lvl);
    int unsigned len;
    int unsigned p;
    logic        pf;
    len = hdr_len;
    pf  = padded_of(hdr_type, hdr_flags);
    p   = prefix_len();
    lvl = 1'b0;
    if (hdr_type > hfp_pkg::FtContinuation) return hfp_pkg::ST_UNKNOWN;
    if (pf && pad_val >= len) return hfp_pkg::ST_PROTO;
    if (hdr_type == hfp_pkg::FtRstStream || hdr_type == hfp_pkg::FtPing ||
        hdr_type == hfp_pkg::FtWindowUpdate) begin
      if (len != fixed_of(hdr_type, hdr_flags)) return hfp_pkg::ST_SIZE;
    end else if (hdr_type == hfp_pkg::FtSettings) begin
      if (hdr_flags[hfp_pkg::FlagAck] ? (len != 0) : (len % SettingSize != 0)) begin
        return hfp_pkg::ST_SIZE;
      end
    end else if (len < p) begin
      lvl = (hdr_type == hfp_pkg::FtPriority);
      return hfp_pkg::ST_SIZE;
    end
    if (pf && pad_val > len - p) return hfp_pkg::ST_PROTO;
    if (hdr_type == hfp_pkg::FtSettings || hdr_type == hfp_pkg::FtPing ||
        hdr_type == hfp_pkg::FtGoaway) begin
      if (hdr_stream != 0) return hfp_pkg::ST_PROTO;
    end else if (hdr_type != hfp_pkg::FtWindowUpdate &&
                 hdr_type != hfp_pkg::FtContinuation) begin
      if (hdr_stream == 0) return hfp_pkg::ST_PROTO;
    end
    return hfp_pkg::ST_OK;
  endfunction

  task automatic push_descriptor(hfp_pkg::status_e st, logic lvl);
    beat_t       e;
    int unsigned pad;
    e   = '0;
    pad = padded_of(hdr_type, hdr_flags) ? pad_val : 0;
    e.kind                = hfp_pkg::KindDescriptor;
    e.data.frame_type     = hdr_type;
    e.data.frame_flags    = hdr_flags;
    e.data.frame_length   = hdr_len;
    e.data.stream_number  = hdr_stream;
    e.data.status         = st;
    e.data.stream_level   = lvl;
    e.data.pad_length     = 8'(pad);
    if (st == hfp_pkg::ST_UNKNOWN) begin
      e.data.content_length = hdr_len;
    end else if (st == hfp_pkg::ST_OK) begin
      e.data.content_length = 24'(hdr_len - prefix_len() - pad);
    end
    if (st == hfp_pkg::ST_OK || st == hfp_pkg::ST_UNKNOWN) begin
      e.data.word_a = word_a;
      e.data.word_b = word_b;
    end
    put_expected(e);
    if (st == hfp_pkg::ST_SIZE || st == hfp_pkg::ST_PROTO) begin
      halted = 1'b1;
    end else if (byte_cnt >= hdr_len) begin
      ph       = PH_HEADER;
      byte_cnt = '0;
    end else begin
      ph = PH_BODY;
    end
  endtask

  task automatic parse_byte(logic [7:0] b);
    hfp_pkg::status_e st;
    logic             lvl;
    logic             pf;
    int unsigned      k;
    int unsigned      limit;
    beat_t            e;
    if (halted) return;
    pf = padded_of(hdr_type, hdr_flags);
    case (ph)
      PH_HEADER: begin
        if (byte_cnt < 3) begin
          hdr_len = {hdr_len[15:0], b};
        end else if (byte_cnt == 3) begin
          hdr_type = b;
        end else if (byte_cnt == 4) begin
          hdr_flags = b;
        end else begin
          hdr_stream = {hdr_stream[23:0], b};
        end
        byte_cnt++;
        if (byte_cnt == hfp_pkg::HdrBytes) begin
          byte_cnt = '0;
          pad_val  = '0;
          word_a   = '0;
          word_b   = '0;
          if (padded_of(hdr_type, hdr_flags)) begin
            if (hdr_len == 0) push_descriptor(hfp_pkg::ST_SIZE, 1'b0);
            else ph = PH_PREFIX;
          end else begin
            st = frame_check(lvl);
            if (st == hfp_pkg::ST_SIZE || st == hfp_pkg::ST_PROTO || prefix_len() == 0) begin
              push_descriptor(st, lvl);
            end else begin
              ph = PH_PREFIX;
            end
          end
        end
      end
      PH_PREFIX: begin
        if (pf && byte_cnt == 0) begin
          pad_val  = b;
          byte_cnt = 24'd1;
          st = frame_check(lvl);
          if (st == hfp_pkg::ST_SIZE || st == hfp_pkg::ST_PROTO ||
              byte_cnt >= prefix_len()) begin
            push_descriptor(st, lvl);
          end
        end else begin
          k = byte_cnt - int'(pf);
          if (k < hfp_pkg::WordBytes) begin
            word_a = {word_a[23:0], b};
          end else if (fixed_of(hdr_type, hdr_flags) == hfp_pkg::PrioBytes) begin
            word_b = {24'd0, b};
          end else begin
            word_b = {word_b[23:0], b};
          end
          byte_cnt++;
          if (byte_cnt >= prefix_len()) push_descriptor(hfp_pkg::ST_OK, 1'b0);
        end
      end
      default: begin
        limit = hdr_len - (pf ? pad_val : 0);
        if (hdr_type <= hfp_pkg::FtContinuation && byte_cnt < limit) begin
          e                   = '0;
          e.kind              = hfp_pkg::KindContent;
          e.data.content_byte = b;
          put_expected(e);
        end
        byte_cnt++;
        if (byte_cnt >= hdr_len) begin
          ph       = PH_HEADER;
          byte_cnt = '0;
        end
      end
    endcase
  endtask

  task automatic push_frame(logic [7:0] typ, logic [7:0] flags, logic [31:0] stream,
                            logic [23:0] len);
    put_byte(len[23:16]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    put_byte(typ);
    put_byte(flags);
    put_byte(stream[31:24]);
    put_byte(stream[23:16]);
    put_byte(stream[15:8]);
    put_byte(stream[7:0]);
    while (body_q.size() != 0) put_byte(body_q.pop_front());
  endtask

  // A well-formed frame: pad byte, fixed fields, n content bytes, then padding.
  task automatic valid_frame(logic [7:0] typ, logic [7:0] flags, logic [31:0] stream,
                             int unsigned n, int unsigned pad);
    logic        pf;
    int unsigned len;
    pf = padded_of(typ, flags);
    if (!pf) pad = 0;
    len = int'(pf) + fixed_of(typ, flags) + n + pad;
    if (pf) put_body(8'(pad));
    repeat (len - int'(pf)) put_body(8'($urandom));
    push_frame(typ, flags, stream, 24'(len));
    bytes_queued += hfp_pkg::HdrBytes + len;
  endtask

  task automatic random_frame();
    logic [7:0]  typ;
    logic [7:0]  flags;
    logic [31:0] stream;
    int unsigned n;
    int unsigned pad;
    if ($urandom_range(0, 15) == 0) begin
      typ = 8'($urandom_range(hfp_pkg::FtContinuation + 1, FtLastUnknown));
    end else begin
      typ = 8'($urandom_range(hfp_pkg::FtData, hfp_pkg::FtContinuation));
    end
    flags  = 8'($urandom);
    stream = $urandom;
    n      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    pad    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 3);
    case (typ)
      hfp_pkg::FtSettings, hfp_pkg::FtPing, hfp_pkg::FtGoaway: begin
        stream = '0;
      end
      hfp_pkg::FtWindowUpdate, hfp_pkg::FtContinuation: begin
        if ($urandom_range(0, 1) == 0) stream = '0;
      end
      default: begin
        if (stream == 0) stream = 32'd1;
      end
    endcase
    if (typ == hfp_pkg::FtSettings) begin
      n = flags[hfp_pkg::FlagAck] ? 0 : SettingSize * (n % 4);
    end else if (typ == hfp_pkg::FtRstStream || typ == hfp_pkg::FtPing ||
                 typ == hfp_pkg::FtWindowUpdate) begin
      n = 0;
    end else if (typ == hfp_pkg::FtPriority && $urandom_range(0, 3) != 0) begin
      n = 0;
    end
    valid_frame(typ, flags, stream, n, pad);
  endtask

  // One frame that fails a check; the parser halts on it for good.
  task automatic error_frame();
    logic [7:0]  typ;
    logic [7:0]  flags;
    logic [7:0]  lead;
    logic [31:0] stream;
    int unsigned len;
    flags  = '0;
    stream = 32'd1 | $urandom;
    lead   = 8'($urandom);
    case ($urandom_range(0, 13))
      0: begin
        typ = hfp_pkg::FtData; flags = PadBit; len = 0;
      end
      1: begin
        typ = hfp_pkg::FtData; flags = PadBit; len = 3; lead = 8'd3;
      end
      2: begin
        typ = hfp_pkg::FtPriority; len = 3;
      end
      3: begin
        typ = hfp_pkg::FtRstStream; len = 5;
      end
      4: begin
        typ = hfp_pkg::FtPing; stream = '0; len = 7;
      end
      5: begin
        typ = hfp_pkg::FtWindowUpdate; len = 3;
      end
      6: begin
        typ = hfp_pkg::FtSettings; flags = AckBit; stream = '0; len = 6;
      end
      7: begin
        typ = hfp_pkg::FtSettings; stream = '0; len = 7;
      end
      8: begin
        typ = hfp_pkg::FtHeaders; flags = PadBit | PrioBit; len = 8; lead = 8'd4;
      end
      9: begin
        typ = hfp_pkg::FtData; stream = '0; len = 2;
      end
      10: begin
        typ = hfp_pkg::FtSettings; stream = 32'h8000_0000; len = 0;
      end
      11: begin
        typ = hfp_pkg::FtGoaway; stream = '0; len = 5;
      end
      12: begin
        typ = hfp_pkg::FtPushPromise; len = 3;
      end
      default: begin
        typ = hfp_pkg::FtPing; len = 8;
      end
    endcase
    if (len != 0) begin
      put_body(lead);
      repeat (len - 1) put_body(8'($urandom));
    end
    push_frame(typ, flags, stream, 24'(len));
    repeat (16) put_byte(8'($urandom));
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_err++;
      if (n_err <= 10) begin
        $display("tb_top: %s mismatch, expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || in_taken) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= byte_q.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // The hold-off at the start lets the parser fill up and stall its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt        <= hold_cnt - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin : monitor
    hfp_pkg::out_data_t got;
    beat_t              want;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        parse_byte(s_axis_tdata_i);
        n_in++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (expected_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("tb_top: unexpected beat %0h", m_axis_tdata_o);
        end else begin
          want = expected_q.pop_front();
          if (want.kind == hfp_pkg::KindDescriptor) n_desc++;
          else n_content++;
          check_field("result_kind", want.kind, m_axis_tuser_o);
          check_field("content_byte", want.data.content_byte, got.content_byte);
          check_field("frame_type", want.data.frame_type, got.frame_type);
          check_field("frame_flags", want.data.frame_flags, got.frame_flags);
          check_field("frame_length", want.data.frame_length, got.frame_length);
          check_field("stream_number", want.data.stream_number, got.stream_number);
          check_field("status", want.data.status, got.status);
          check_field("stream_level", want.data.stream_level, got.stream_level);
          check_field("pad_length", want.data.pad_length, got.pad_length);
          check_field("content_length", want.data.content_length, got.content_length);
          check_field("word_a", want.data.word_a, got.word_a);
          check_field("word_b", want.data.word_b, got.word_b);
          check_field("fill", want.data.fill, got.fill);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt == QuietLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  initial begin
    int unsigned target;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int step = 0; step < 4; step++) begin
      case (step)
        0: begin
          send_idle = 0;  recv_idle = 0;
        end
        1: begin
          send_idle = 70; recv_idle = 0;
        end
        2: begin
          send_idle = 0;  recv_idle = 70;
        end
        default: begin
          send_idle = 34; recv_idle = 34;
        end
      endcase
      if (step == 0) begin
        valid_frame(hfp_pkg::FtData, 8'h00, 32'd1, 0, 0);
        valid_frame(hfp_pkg::FtData, PadBit, 32'hFFFF_FFFF, 3, 0);
        valid_frame(hfp_pkg::FtData, 8'hFF, 32'h8000_0000, 2, 255);
        valid_frame(hfp_pkg::FtData, PadBit, 32'd5, 0, 4);
        valid_frame(hfp_pkg::FtHeaders, PadBit | PrioBit, 32'd3, 3, 2);
        valid_frame(hfp_pkg::FtHeaders, PrioBit, 32'h7FFF_FFFF, 0, 0);
        valid_frame(hfp_pkg::FtHeaders, 8'h00, 32'd9, 4, 0);
        valid_frame(hfp_pkg::FtPriority, 8'h00, 32'd1, 0, 0);
        valid_frame(hfp_pkg::FtPriority, 8'hFF, 32'd2, 3, 0);
        valid_frame(hfp_pkg::FtRstStream, 8'hFF, 32'd11, 0, 0);
        valid_frame(hfp_pkg::FtSettings, AckBit, 32'd0, 0, 0);
        valid_frame(hfp_pkg::FtSettings, 8'h00, 32'd0, 0, 0);
        valid_frame(hfp_pkg::FtSettings, 8'h00, 32'd0, 2 * SettingSize, 0);
        valid_frame(hfp_pkg::FtSettings, 8'hFE, 32'd0, SettingSize, 0);
        valid_frame(hfp_pkg::FtPushPromise, PadBit, 32'd13, 2, 1);
        valid_frame(hfp_pkg::FtPushPromise, 8'h00, 32'd15, 0, 0);
        valid_frame(hfp_pkg::FtPing, AckBit, 32'd0, 0, 0);
        valid_frame(hfp_pkg::FtPing, 8'hFF, 32'd0, 0, 0);
        valid_frame(hfp_pkg::FtGoaway, 8'h00, 32'd0, 0, 0);
        valid_frame(hfp_pkg::FtGoaway, 8'h00, 32'd0, 5, 0);
        valid_frame(hfp_pkg::FtWindowUpdate, 8'h00, 32'd0, 0, 0);
        valid_frame(hfp_pkg::FtWindowUpdate, 8'hFF, 32'd7, 0, 0);
        valid_frame(hfp_pkg::FtContinuation, 8'hFF, 32'd0, 2, 0);
        valid_frame(hfp_pkg::FtContinuation + 8'd1, 8'h00, 32'd1, 3, 0);
        valid_frame(FtLastUnknown, 8'hFF, 32'd0, 0, 0);
        valid_frame(FtLastUnknown, 8'h00, 32'hFFFF_FFFF, 20, 0);
      end
      target = bytes_queued + PhaseBytes;
      while (bytes_queued < target) random_frame();
      if (step == 3) error_frame();
      while (byte_q.size() != 0) @(posedge clk_i);
    end

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb_top: %0d bytes sent, %0d descriptors and %0d content bytes checked",
             n_in, n_desc, n_content);
    $display("tb_top: all frame types, four idling mixes and a long output stall; halted %0b",
             halted);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
